// ----- rtl/nsfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfp_pkg
// Types, character codes and sentence schedules for the NMEA field parser.
// ----------------------------------------------------------------------------
package nsfp_pkg;

	// parser phases
	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_ID     = 2'd1;
	localparam logic [1:0] PH_FIELDS = 2'd2;

	// field kinds
	localparam logic [1:0] K_NUM  = 2'd0;
	localparam logic [1:0] K_FLAG = 2'd1;
	localparam logic [1:0] K_TEXT = 2'd2;

	// sentence codes
	localparam logic [2:0] SENT_GGA  = 3'd0;
	localparam logic [2:0] SENT_HDG  = 3'd1;
	localparam logic [2:0] SENT_RMB  = 3'd2;
	localparam logic [2:0] SENT_RMC  = 3'd3;
	localparam logic [2:0] SENT_VTG  = 3'd4;
	localparam logic [2:0] SENT_LOST = 3'd5;

	// characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [39:0] NAME_GGA = "GPGGA";
	localparam logic [39:0] NAME_HDG = "GPHDG";
	localparam logic [39:0] NAME_RMB = "GPRMB";
	localparam logic [39:0] NAME_RMC = "GPRMC";
	localparam logic [39:0] NAME_VTG = "GPVTG";

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  sentence;
		logic [3:0]  field_index;
		logic [1:0]  field_kind;
		logic [31:0] number;
		logic        flag;
		logic        last_field;
	} result_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] arg;   // fraction places for numbers, expected letter for flags
	} field_desc_t;

	function automatic field_desc_t fd(input logic [1:0] kind, input logic [7:0] arg);
		field_desc_t d;
		d.kind = kind;
		d.arg  = arg;
		return d;
	endfunction

	function automatic field_desc_t sched_lookup(input logic [2:0] s, input logic [3:0] idx);
		field_desc_t d;
		d = fd(K_NUM, 8'd0);
		case (s)
			SENT_GGA: begin
				case (idx)
					4'd1, 4'd3: d = fd(K_NUM, 8'd3);
					4'd2:       d = fd(K_FLAG, "N");
					4'd4:       d = fd(K_FLAG, "E");
					default:    d = fd(K_NUM, 8'd0);
				endcase
			end
			SENT_HDG: begin
				case (idx)
					4'd0:       d = fd(K_NUM, 8'd2);
					4'd1, 4'd3: d = fd(K_NUM, 8'd3);
					4'd2, 4'd4: d = fd(K_FLAG, "E");
					default:    d = fd(K_NUM, 8'd0);
				endcase
			end
			SENT_RMB: begin
				case (idx)
					4'd0, 4'd12:       d = fd(K_FLAG, "A");
					4'd1, 4'd9, 4'd11: d = fd(K_NUM, 8'd2);
					4'd2:              d = fd(K_FLAG, "L");
					4'd3, 4'd4:        d = fd(K_TEXT, 8'd0);
					4'd5, 4'd7:        d = fd(K_NUM, 8'd3);
					4'd6:              d = fd(K_FLAG, "N");
					4'd8:              d = fd(K_FLAG, "E");
					4'd10:             d = fd(K_NUM, 8'd1);
					default:           d = fd(K_NUM, 8'd0);
				endcase
			end
			SENT_RMC: begin
				case (idx)
					4'd1:              d = fd(K_FLAG, "A");
					4'd2, 4'd4, 4'd6:  d = fd(K_NUM, 8'd3);
					4'd3:              d = fd(K_FLAG, "N");
					4'd5, 4'd10:       d = fd(K_FLAG, "E");
					4'd7, 4'd9:        d = fd(K_NUM, 8'd2);
					default:           d = fd(K_NUM, 8'd0);
				endcase
			end
			SENT_VTG: begin
				case (idx)
					4'd1:    d = fd(K_FLAG, "T");
					4'd3:    d = fd(K_FLAG, "M");
					4'd5:    d = fd(K_FLAG, "N");
					default: d = fd(K_NUM, 8'd1);
				endcase
			end
			default: d = fd(K_NUM, 8'd0);
		endcase
		return d;
	endfunction

	function automatic logic [3:0] sched_len(input logic [2:0] s);
		logic [3:0] n;
		case (s)
			SENT_GGA: n = 4'd7;
			SENT_HDG: n = 4'd5;
			SENT_RMB: n = 4'd13;
			SENT_RMC: n = 4'd11;
			SENT_VTG: n = 4'd7;
			default:  n = 4'd13;
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/nsfp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfp_in_stage
// Input register: captures one received byte or timeout event per transaction.
// ----------------------------------------------------------------------------
module nsfp_in_stage import nsfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  out_free,
	output logic  valid_s1,
	output logic  advance,
	output item_t item_s1
);

	logic vld_s1;

	assign valid_s1 = vld_s1;
	assign advance  = vld_s1 & out_free;
	assign in_ready = ~vld_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// hold the payload until the engine takes it
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- rtl/nsfp_field_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsfp_field_engine
// Sentence state, field scanning and the result register.
// ----------------------------------------------------------------------------
module nsfp_field_engine import nsfp_pkg::*; #(
	parameter int TOKEN_BUF = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	input  logic    out_ready,
	output logic    out_free,
	output logic    out_valid,
	output result_t res
);

	localparam int TLW = $clog2(TOKEN_BUF);

	logic [1:0]     phase_q, n_phase;
	logic [7:0]     id_q [0:4];
	logic [7:0]     n_id [0:4];
	logic [2:0]     id_len_q, n_id_len;
	logic [2:0]     kind_q, n_kind;
	logic [3:0]     fnum_q, n_fnum;
	logic [TLW-1:0] tok_q, n_tok;
	logic [31:0]    acc_q, n_acc;
	logic           frac_q, n_frac;
	logic [1:0]     places_q, n_places;
	logic           stop_q, n_stop;
	logic [7:0]     first_q, n_first;

	logic           emit;
	result_t        res_d;
	logic           out_valid_q;
	field_desc_t    cur;
	field_desc_t    nxt;
	logic [39:0]    id_word;

	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | out_ready;

	always_comb begin
		logic [7:0] c;
		logic       tok_end;
		logic       start;
		logic       is_last;
		c        = item_s1.rx_byte;
		tok_end  = 1'b0;
		start    = 1'b0;
		is_last  = 1'b0;
		n_phase  = phase_q;
		n_id     = id_q;
		n_id_len = id_len_q;
		n_kind   = kind_q;
		n_fnum   = fnum_q;
		n_tok    = tok_q;
		n_acc    = acc_q;
		n_frac   = frac_q;
		n_places = places_q;
		n_stop   = stop_q;
		n_first  = first_q;
		emit     = 1'b0;
		res_d    = '0;
		id_word  = '0;
		cur      = sched_lookup(kind_q, fnum_q);

		if (item_s1.func) begin
			n_phase        = PH_HUNT;
			start          = 1'b1;
			emit           = 1'b1;
			res_d.sentence = SENT_LOST;
		end else if (phase_q == PH_HUNT) begin
			if (c == CH_DOLLAR) begin
				n_phase  = PH_ID;
				n_id_len = 3'd0;
				start    = 1'b1;
			end
		end else begin
			if (c == CH_COMMA || c == CH_STAR) begin
				tok_end = 1'b1;
			end else begin
				if (phase_q == PH_ID) begin
					if (!stop_q) begin
						if (c == CH_NUL) begin
							n_stop = 1'b1;
						end else begin
							if (id_len_q < 3'd5) n_id[id_len_q] = c;
							if (id_len_q < 3'd6) n_id_len = id_len_q + 3'd1;
						end
					end
				end else begin
					if (tok_q == '0) n_first = c;
					if (cur.kind == K_NUM && !stop_q) begin
						if (c == CH_NUL) begin
							n_stop = 1'b1;
						end else if (c == CH_DOT) begin
							n_frac = 1'b1;
						end else if (frac_q && places_q == 2'd0) begin
							n_stop = 1'b1;
						end else begin
							if (frac_q) n_places = places_q - 2'd1;
							if (c < CH_ZERO || c > CH_NINE) begin
								n_stop = 1'b1;
							end else begin
								n_acc = (acc_q << 3) + (acc_q << 1) + {24'd0, c - CH_ZERO};
							end
						end
					end
				end
				n_tok = tok_q + 1'b1;
				if (tok_q == TLW'(TOKEN_BUF - 2)) tok_end = 1'b1;
			end

			if (tok_end) begin
				start = 1'b1;
				if (phase_q == PH_ID) begin
					id_word = {n_id[0], n_id[1], n_id[2], n_id[3], n_id[4]};
					n_phase = PH_FIELDS;
					n_fnum  = 4'd0;
					if (n_id_len != 3'd5) begin
						n_phase = PH_HUNT;
					end else if (id_word == NAME_GGA) begin
						n_kind = SENT_GGA;
					end else if (id_word == NAME_HDG) begin
						n_kind = SENT_HDG;
					end else if (id_word == NAME_RMB) begin
						n_kind = SENT_RMB;
					end else if (id_word == NAME_RMC) begin
						n_kind = SENT_RMC;
					end else if (id_word == NAME_VTG) begin
						n_kind = SENT_VTG;
					end else begin
						n_phase = PH_HUNT;
						n_fnum  = fnum_q;
					end
				end else begin
					is_last = (fnum_q + 4'd1) >= sched_len(kind_q);
					emit              = 1'b1;
					res_d.sentence    = kind_q;
					res_d.field_index = fnum_q;
					res_d.field_kind  = cur.kind;
					res_d.last_field  = is_last;
					if (cur.kind == K_NUM) begin
						// pad with a constant power of ten for the places still left
						case (n_places)
							2'd1:    res_d.number = n_acc * 32'd10;
							2'd2:    res_d.number = n_acc * 32'd100;
							2'd3:    res_d.number = n_acc * 32'd1000;
							default: res_d.number = n_acc;
						endcase
					end else if (cur.kind == K_FLAG) begin
						res_d.flag = (n_first == cur.arg);
					end
					if (is_last) begin
						n_phase = PH_HUNT;
						n_fnum  = 4'd0;
					end else begin
						n_fnum = fnum_q + 4'd1;
					end
				end
			end
		end

		nxt = sched_lookup(n_kind, n_fnum);
		if (start) begin
			n_tok    = '0;
			n_acc    = '0;
			n_frac   = 1'b0;
			n_stop   = 1'b0;
			n_first  = '0;
			n_places = (n_phase == PH_FIELDS && nxt.kind == K_NUM) ? nxt.arg[1:0] : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			id_q     <= '{default: 8'd0};
			id_len_q <= '0;
			kind_q   <= '0;
			fnum_q   <= '0;
			tok_q    <= '0;
			acc_q    <= '0;
			frac_q   <= 1'b0;
			places_q <= '0;
			stop_q   <= 1'b0;
			first_q  <= '0;
		end else if (advance) begin
			phase_q  <= n_phase;
			id_q     <= n_id;
			id_len_q <= n_id_len;
			kind_q   <= n_kind;
			fnum_q   <= n_fnum;
			tok_q    <= n_tok;
			acc_q    <= n_acc;
			frac_q   <= n_frac;
			places_q <= n_places;
			stop_q   <= n_stop;
			first_q  <= n_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance & emit;
		end
	end

	// load the result only when a transaction is produced
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.func |=> out_valid_q && res.sentence == SENT_LOST)
		else $error("timeout did not produce a signal-lost result");

	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res.sentence == SENT_LOST |->
			res.number == 32'd0 && res.field_index == 4'd0 && !res.last_field)
		else $error("signal-lost result carries field data");

	a_tok_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q <= TLW'(TOKEN_BUF - 2))
		else $error("token length passed the buffer limit");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> tok_q == '0 && acc_q == 32'd0 && places_q == 2'd0)
		else $error("token state not cleared while hunting");

	a_fnum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIELDS |-> fnum_q < sched_len(kind_q))
		else $error("field number beyond the sentence schedule");
`endif

endmodule

// ----- rtl/nmea_sentence_field_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_field_parser_core
// NMEA 0183 sentence parser: splits GGA/HDG/RMB/RMC/VTG into decoded fields.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one received character (s_tdata) or one
//   receive-timeout event (s_tuser = 1) per transaction. The master channel
//   carries at most one decoded field per input transaction: sentence and
//   field kind in m_tuser, field index, scaled number and flag in m_tdata,
//   and m_tlast on the final field of a sentence schedule. A timeout yields a
//   signal-lost transaction and drops any sentence in progress.
//   The input register takes each accepted transaction; the engine then
//   loads the result register once the output has room, and m_tvalid rises
//   with it for the closing transaction. The parser takes one input
//   transaction per cycle while the output does not stall.
//   While a result waits with m_tready low the engine holds, also for bytes
//   that give no field; the input register takes one more transaction, then
//   s_tready drops and everything holds.
//   Reset (arst_n low) empties both registers and returns the parser to
//   hunting for '$'.
// ----------------------------------------------------------------------------
module nmea_sentence_field_parser_core import nsfp_pkg::*; #(
	parameter int TOKEN_BUF = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] field_index, [35:4] number, [36] flag, zero pad
	output logic [4:0]  m_tuser,   // [2:0] sentence, [4:3] field_kind
	output logic        m_tlast    // last_field
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    out_free;
	result_t res;

	assign in_item.func    = s_tuser;
	assign in_item.rx_byte = s_tdata;

	nsfp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.advance  (advance),
		.item_s1  (item_s1)
	);

	nsfp_field_engine #(
		.TOKEN_BUF (TOKEN_BUF)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item_s1   (item_s1),
		.out_ready (m_tready),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.res       (res)
	);

	assign m_tdata = {3'b000, res.flag, res.number, res.field_index};
	assign m_tuser = {res.field_kind, res.sentence};
	assign m_tlast = res.last_field;

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while both registers are full");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input refused with an empty input register");

	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1 && (!m_tvalid || m_tready))
		else $error("engine advanced without room for a result");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the NMEA sentence field parser.
// A byte stream of valid, cut-short and malformed sentences, line noise and
// receive timeouts is pushed through the slave port. Both ports idle at random,
// and once the output holds off long enough to stall the input. Every
// accepted transaction runs through a local parser model, and each output
// transaction is compared with the oldest predicted field.
// ----------------------------------------------------------------------------
module testbench;
	import nsfp_pkg::*;

	localparam int TOKEN_BUF = 16;
	localparam int STREAM_ITEMS = 1850;

	class field_scoreboard;
		result_t     expected_q[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned per_sentence[6];

		// parser state
		logic [1:0]  phase;
		logic [7:0]  id_buf[5];
		int unsigned id_count;
		logic [2:0]  kind_sel;
		logic [3:0]  field_no;
		int unsigned tok_len;
		logic [31:0] acc;
		bit          frac;
		logic [1:0]  places;
		bit          stopped;
		logic [7:0]  lead_char;

		function new();
			phase = PH_HUNT;
			foreach (id_buf[k]) id_buf[k] = '0;
			id_count = 0;
			kind_sel = '0;
			field_no = '0;
			errors = 0;
			checked = 0;
			foreach (per_sentence[k]) per_sentence[k] = 0;
			open_token();
		endfunction

		// Field schedule per sentence: a digit is a number with that many
		// fraction places, a letter is a flag, '-' is skipped text.
		static function string layout(logic [2:0] s);
			case (s)
				SENT_GGA: return "03N3E00";
				SENT_HDG: return "23E3E";
				SENT_RMB: return "A2L--3N3E212A";
				SENT_RMC: return "0A3N3E3202E";
				default:  return "1T1M1N1";
			endcase
		endfunction

		static function string talker(logic [2:0] s);
			case (s)
				SENT_GGA: return "GPGGA";
				SENT_HDG: return "GPHDG";
				SENT_RMB: return "GPRMB";
				SENT_RMC: return "GPRMC";
				default:  return "GPVTG";
			endcase
		endfunction

		function void field_spec(output logic [1:0] fk, output logic [7:0] arg);
			string      lay;
			logic [7:0] code;
			lay = layout(kind_sel);
			code = lay[field_no];
			if (code >= "0" && code <= "3") begin
				fk = K_NUM;
				arg = code - "0";
			end else if (code == "-") begin
				fk = K_TEXT;
				arg = '0;
			end else begin
				fk = K_FLAG;
				arg = code;
			end
		endfunction

		function void open_token();
			logic [1:0] fk;
			logic [7:0] arg;
			tok_len = 0;
			acc = '0;
			frac = 0;
			stopped = 0;
			lead_char = '0;
			places = '0;
			if (phase == PH_FIELDS) begin
				field_spec(fk, arg);
				if (fk == K_NUM) places = arg[1:0];
			end
		endfunction

		function void take_digit(logic [7:0] c);
			if (stopped) return;
			if (c == CH_NUL) begin
				stopped = 1;
				return;
			end
			if (c == CH_DOT) begin
				frac = 1;
				return;
			end
			if (frac) begin
				if (places == 0) begin
					stopped = 1;
					return;
				end
				places--;
			end
			if (c < CH_ZERO || c > CH_NINE) begin
				stopped = 1;
				return;
			end
			acc = acc * 10 + 32'(c - CH_ZERO);
		endfunction

		function void take_id(logic [7:0] c);
			if (stopped) return;
			if (c == CH_NUL) begin
				stopped = 1;
				return;
			end
			if (id_count < 5) id_buf[id_count] = c;
			if (id_count < 6) id_count++;
		endfunction

		function void push_field(result_t r);
			expected_q.push_back(r);
			per_sentence[r.sentence]++;
		endfunction

		// Advance the parser model by one accepted transaction.
		function void note_input(logic func, logic [7:0] c);
			bit         closed;
			bit         hit;
			logic [1:0] fk;
			logic [7:0] arg;
			result_t    r;
			string      t;
			int         s;
			int         k;
			if (func) begin
				phase = PH_HUNT;
				open_token();
				r = '0;
				r.sentence = SENT_LOST;
				push_field(r);
				return;
			end
			if (phase == PH_HUNT) begin
				if (c == CH_DOLLAR) begin
					phase = PH_ID;
					id_count = 0;
					open_token();
				end
				return;
			end
			closed = 0;
			if (c == CH_COMMA || c == CH_STAR) begin
				closed = 1;
			end else begin
				if (phase == PH_ID) begin
					take_id(c);
				end else begin
					field_spec(fk, arg);
					if (tok_len == 0) lead_char = c;
					if (fk == K_NUM) take_digit(c);
				end
				tok_len++;
				if (tok_len >= TOKEN_BUF - 1) closed = 1;
			end
			if (!closed) return;

			if (phase == PH_ID) begin
				phase = PH_HUNT;
				if (id_count == 5) begin
					for (s = 0; s < 5; s++) begin
						t = talker(3'(s));
						hit = 1;
						for (k = 0; k < 5; k++) if (id_buf[k] != t[k]) hit = 0;
						if (hit) begin
							kind_sel = 3'(s);
							field_no = '0;
							phase = PH_FIELDS;
						end
					end
				end
				open_token();
				return;
			end

			field_spec(fk, arg);
			t = layout(kind_sel);
			r = '0;
			r.sentence = kind_sel;
			r.field_index = field_no;
			r.field_kind = fk;
			if (fk == K_NUM) begin
				r.number = acc;
				repeat (places) r.number = r.number * 10;
			end else if (fk == K_FLAG) begin
				r.flag = (lead_char == arg);
			end
			r.last_field = (field_no + 1 >= t.len());
			push_field(r);
			if (r.last_field) begin
				phase = PH_HUNT;
				field_no = '0;
			end else begin
				field_no++;
			end
			open_token();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("%0t ERROR: %s", $time, msg);
		endtask

		task check(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.sentence !== want.sentence)
				report($sformatf("sentence got %0d want %0d", got.sentence, want.sentence));
			if (got.field_index !== want.field_index)
				report($sformatf("field_index got %0d want %0d", got.field_index,
					want.field_index));
			if (got.field_kind !== want.field_kind)
				report($sformatf("field_kind got %0d want %0d", got.field_kind,
					want.field_kind));
			if (got.number !== want.number)
				report($sformatf("number got %0d want %0d (sentence %0d field %0d)",
					got.number, want.number, want.sentence, want.field_index));
			if (got.flag !== want.flag)
				report($sformatf("flag got %b want %b (sentence %0d field %0d)",
					got.flag, want.flag, want.sentence, want.field_index));
			if (got.last_field !== want.last_field)
				report($sformatf("last_field got %b want %b", got.last_field,
					want.last_field));
		endtask

		task drain();
			result_t want;
			while (expected_q.size() != 0) begin
				want = expected_q.pop_front();
				report($sformatf("no result for sentence %0d field %0d", want.sentence,
					want.field_index));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	field_scoreboard sb = new();
	item_t           stim_q[$];
	int unsigned     stream_count = 0;
	int unsigned     sent = 0;
	int unsigned     timeouts_sent = 0;
	int unsigned     sentences_sent = 0;
	bit              calm_tx = 0;
	bit              calm_rx = 0;
	logic            hold_rx = 1'b0;

	nmea_sentence_field_parser_core #(
		.TOKEN_BUF(TOKEN_BUF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ---- stream construction ----

	task automatic put_char(logic [7:0] c, bit counted);
		item_t it;
		it.func = 1'b0;
		it.rx_byte = c;
		stim_q.push_back(it);
		if (counted) stream_count++;
	endtask

	task automatic put_text(string t, bit counted);
		int i;
		for (i = 0; i < t.len(); i++) put_char(t[i], counted);
	endtask

	task automatic put_timeout();
		item_t it;
		it.func = 1'b1;
		it.rx_byte = 8'($urandom_range(0, 255));
		stim_q.push_back(it);
		stream_count++;
		timeouts_sent++;
	endtask

	task automatic put_digits(int unsigned n);
		repeat (n) put_char(CH_ZERO + 8'($urandom_range(0, 9)), 1);
	endtask

	function automatic logic [7:0] any_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA || c == CH_STAR);
		return c;
	endfunction

	task automatic gen_number(int unsigned frac_places);
		case ($urandom_range(0, 15))
			0: ;
			1, 2, 3, 4, 5, 6, 7: begin
				put_digits($urandom_range(1, 4));
				if ($urandom_range(0, 3) != 0) begin
					put_char(CH_DOT, 1);
					put_digits($urandom_range(0, frac_places + 2));
				end
			end
			// long runs wrap the value and may hit the length cut
			8, 9: put_digits($urandom_range(9, 16));
			10: begin
				put_digits(2);
				put_char(CH_DOT, 1);
				put_digits(1);
				put_char(CH_DOT, 1);
				put_digits(2);
			end
			11: begin
				put_digits($urandom_range(0, 3));
				put_char(8'($urandom_range("A", "Z")), 1);
				put_digits(2);
			end
			12: begin
				put_digits($urandom_range(0, 3));
				put_char(CH_NUL, 1);
				put_digits(2);
			end
			13: begin
				put_char(CH_DOT, 1);
				put_digits($urandom_range(1, 5));
			end
			14: repeat ($urandom_range(1, 4)) put_char(any_char(), 1);
			default: put_char(CH_DOT, 1);
		endcase
	endtask

	task automatic gen_field(logic [7:0] code);
		if (code >= "0" && code <= "3") begin
			gen_number(code - "0");
		end else if (code == "-") begin
			repeat ($urandom_range(0, 6)) put_char(any_char(), 1);
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: put_char(code, 1);
				6: put_char(8'($urandom_range("A", "Z")), 1);
				7: ;
				8: begin
					put_char(code, 1);
					repeat ($urandom_range(1, 3)) put_char(any_char(), 1);
				end
				default: put_char(any_char(), 1);
			endcase
		end
	endtask

	// Stop after the field numbered cut when cut is within the schedule.
	task automatic gen_sentence(int cut);
		int    s;
		int    i;
		string lay;
		s = $urandom_range(0, 4);
		lay = field_scoreboard::layout(3'(s));
		sentences_sent++;
		put_char(CH_DOLLAR, 1);
		put_text(field_scoreboard::talker(3'(s)), 1);
		if ($urandom_range(0, 19) == 0) begin
			put_char(CH_NUL, 1);
			put_char(any_char(), 1);
		end
		put_char(CH_COMMA, 1);
		for (i = 0; i < lay.len(); i++) begin
			gen_field(lay[i]);
			if (i == cut) return;
			if (i == lay.len() - 1 || $urandom_range(0, 29) == 0)
				put_char(CH_STAR, 1);
			else
				put_char(CH_COMMA, 1);
		end
		// checksum and line end fall in the hunt phase
		put_text("5A\r\n", 0);
	endtask

	task automatic gen_bad_id();
		put_char(CH_DOLLAR, 1);
		case ($urandom_range(0, 6))
			0: put_text("GPGGB", 1);
			1: begin
				put_text("GP", 1);
				put_char(CH_NUL, 1);
				put_text("GGA", 1);
			end
			2: ;
			3: put_text("GPRMCC", 1);
			4: repeat (16) put_char(8'($urandom_range("A", "Z")), 1);
			5: put_text("GPGG", 1);
			default: put_text("gpvtg", 1);
		endcase
		put_char(CH_COMMA, 1);
		put_text("12.5,A\r\n", 0);
	endtask

	task automatic build_stream();
		// directed: timeout in hunt, empty and cut-short numbers, matching and
		// failing flags, zero byte in a number, timeout inside a sentence
		put_timeout();
		put_text("$GPHDG,,7.,E,5", 1);
		put_char(CH_NUL, 1);
		put_text("9,F*", 1);
		put_text("$GPVTG,3", 1);
		put_timeout();

		while (stim_q.size() < STREAM_ITEMS) begin
			case ($urandom_range(0, 99)) inside
				[0:54]: gen_sentence(-1);
				[55:66]: begin
					gen_sentence($urandom_range(0, 12));
					if ($urandom_range(0, 1) == 0) put_timeout();
					else put_char(CH_DOLLAR, 1);
				end
				[67:76]: gen_bad_id();
				[77:88]: repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(0, 255)), 0);
				default: put_timeout();
			endcase
		end
	endtask

	// ---- drivers ----

	task automatic send_stream();
		item_t       it;
		int unsigned gap;
		while (stim_q.size() != 0) begin
			it = stim_q.pop_front();
			if (sent % 128 == 0) calm_tx = ($urandom_range(0, 3) == 0);
			gap = calm_tx ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser <= it.func;
			s_tdata <= it.rx_byte;
			do @(posedge clk); while (s_tready !== 1'b1);
			sb.note_input(it.func, it.rx_byte);
			sent++;
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin : receiver
		result_t     got;
		int unsigned stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got.sentence = m_tuser[2:0];
				got.field_kind = m_tuser[4:3];
				got.field_index = m_tdata[3:0];
				got.number = m_tdata[35:4];
				got.flag = m_tdata[36];
				got.last_field = m_tlast;
				sb.check(got);
				if (sb.checked % 64 == 0) calm_rx = ($urandom_range(0, 3) == 0);
				stall = calm_rx ? 0 : $urandom_range(0, 5);
			end
			if (hold_rx) begin
				m_tready <= 1'b0;
			end else if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Hold the output off long enough that both registers fill and the
	// input stalls while the sender keeps offering.
	initial begin : backpressure
		wait (sent >= 600);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (300) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin : main
		int unsigned guard;
		build_stream();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_stream();

		guard = 0;
		while (sb.expected_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		// catch any extra result behind the last expected one
		repeat (16) @(posedge clk);
		sb.drain();

		$display("Run covered %0d input transactions (%0d inside sentences or timeouts): %0d sentences started, %0d timeouts",
			sent, stream_count, sentences_sent, timeouts_sent);
		$display("Fields checked %0d (GGA %0d HDG %0d RMB %0d RMC %0d VTG %0d lost %0d)",
			sb.checked, sb.per_sentence[SENT_GGA], sb.per_sentence[SENT_HDG],
			sb.per_sentence[SENT_RMB], sb.per_sentence[SENT_RMC],
			sb.per_sentence[SENT_VTG], sb.per_sentence[SENT_LOST]);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
